// ===== hw/rtl/hte_pkg.sv =====
// Shared types and constants of the Huffman table encoder.
// Used by the channel interfaces and by the top level; depends on nothing.

package hte_pkg;

	localparam int HTE_MAX_CODE_LEN = 32;
	localparam int HTE_SYMBOL_COUNT = 256;

	localparam int OP_W    = 2;
	localparam int SYM_W   = 8;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int TOTAL_W = 48;
	localparam int PEND_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
	} cmd_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               last;
		logic [TOTAL_W-1:0] bit_sum;
	} res_item_t;

endpackage

// ===== hw/rtl/hte_cmd_if.sv =====
// Command channel of the Huffman table encoder: valid, ready and one item.
// Depends on hte_pkg for the item type.

interface hte_cmd_if import hte_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hte_res_if.sv =====
// Result channel of the Huffman table encoder: valid, ready and one item.
// Depends on hte_pkg for the item type.

interface hte_res_if import hte_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/huffman_table_encoder.sv =====
// Huffman table encoder with a code table memory and an MSB-first byte packer.
// An encode item is read from the table in the lookup stage, then its bytes are registered.
// One item is accepted per cycle while each gives at most one byte and res is ready;
// an item that produces k bytes holds the output byte buffer until all are taken.
// Reset clears the pending bits, the bit total and the per-entry valid flags at once.
// Depends on hte_pkg, hte_cmd_if and hte_res_if.

module huffman_table_encoder import hte_pkg::*; #(
	parameter int MAX_CODE_LEN = HTE_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = HTE_SYMBOL_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	hte_cmd_if.sink   cmd,
	hte_res_if.source res
);

	localparam int ADDR_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int ENTRY_W  = LEN_W + MAX_CODE_LEN;
	localparam int ACC_W    = MAX_CODE_LEN + PEND_W;
	localparam int CNT_W    = $clog2(ACC_W + 1);
	localparam int EM_BYTES = ACC_W / BYTE_W;
	localparam int EM_W     = EM_BYTES * BYTE_W;
	localparam int EMC_W    = $clog2(EM_BYTES + 1);

	logic [ENTRY_W-1:0] mem [SYMBOL_COUNT];
	logic               vld_q [SYMBOL_COUNT];

	logic               s1_valid_q;
	logic [OP_W-1:0]    op_s1;
	logic               sym_ok_s1;
	logic [ENTRY_W-1:0] rd_s1;
	logic               vld_s1;

	logic [PEND_W-1:0]  pend_q;
	logic [2:0]         pend_cnt_q;
	logic [TOTAL_W-1:0] total_q;

	logic [EM_W-1:0]    em_data_q;
	logic [EMC_W-1:0]   em_cnt_q;
	logic [TOTAL_W-1:0] em_total_q;

	logic               cmd_fire;
	logic               res_fire;
	logic               sym_ok;
	logic [ADDR_W-1:0]  addr;
	logic [LEN_W-1:0]   len_sat;
	logic [CODE_W-1:0]  load_mask;
	logic [CODE_W-1:0]  code_masked;

	logic [LEN_W-1:0]        len_s1;
	logic [MAX_CODE_LEN-1:0] code_s1;
	logic                    enc_hit;
	logic [ACC_W-1:0]        acc;
	logic [CNT_W-1:0]        cnt;
	logic [EM_W-1:0]         aligned;
	logic [PEND_W-1:0]       pend_mask;
	logic [BYTE_W-1:0]       fl_byte;
	logic [EMC_W-1:0]        s1_nres;
	logic [EM_W-1:0]         s1_data;
	logic                    em_free;
	logic                    s1_adv;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign res_fire = res.valid && res.ready;
	assign sym_ok   = {1'b0, cmd.data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
	assign addr     = cmd.data.symbol[ADDR_W-1:0];

	assign len_sat = (cmd.data.length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
		: cmd.data.length;
	assign load_mask   = CODE_W'(((CODE_W + 1)'(1) << len_sat) - (CODE_W + 1)'(1));
	assign code_masked = cmd.data.code & load_mask;

	always_ff @(posedge clk) begin
		if (cmd_fire && sym_ok) begin
			if (cmd.data.op == OP_LOAD) begin
				mem[addr] <= {len_sat, code_masked[MAX_CODE_LEN-1:0]};
			end
			rd_s1  <= mem[addr];
			vld_s1 <= vld_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOL_COUNT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (cmd_fire && sym_ok && cmd.data.op == OP_LOAD) begin
			vld_q[addr] <= 1'b1;
		end
	end

	assign len_s1  = vld_s1 ? rd_s1[ENTRY_W-1:MAX_CODE_LEN] : '0;
	assign code_s1 = rd_s1[MAX_CODE_LEN-1:0];
	assign enc_hit = op_s1 == OP_ENCODE && sym_ok_s1 && len_s1 != '0;

	assign acc       = (ACC_W'(pend_q) << len_s1) | ACC_W'(code_s1);
	assign cnt       = CNT_W'(pend_cnt_q) + CNT_W'(len_s1);
	assign aligned   = EM_W'((acc << (CNT_W'(ACC_W) - cnt)) >> (ACC_W - EM_W));
	assign pend_mask = ~({PEND_W{1'b1}} << cnt[2:0]);
	assign fl_byte   = BYTE_W'(pend_q) << (4'd8 - {1'b0, pend_cnt_q});

	always_comb begin
		s1_nres = '0;
		s1_data = aligned;
		if (enc_hit) begin
			s1_nres = EMC_W'(cnt >> 3);
		end else if (op_s1 == OP_FLUSH && pend_cnt_q != '0) begin
			s1_nres = EMC_W'(1);
			s1_data = EM_W'(fl_byte) << (EM_W - BYTE_W);
		end
	end

	assign em_free  = em_cnt_q == '0 || (em_cnt_q == EMC_W'(1) && res.ready);
	assign s1_adv   = s1_valid_q && (s1_nres == '0 || em_free);
	assign cmd.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk) begin
		if (cmd.ready) begin
			op_s1     <= cmd.data.op;
			sym_ok_s1 <= sym_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			pend_q     <= '0;
			pend_cnt_q <= '0;
			total_q    <= '0;
		end else begin
			if (cmd.ready) begin
				s1_valid_q <= cmd_fire && cmd.data.op != OP_LOAD;
			end
			if (s1_adv && enc_hit) begin
				pend_q     <= acc[PEND_W-1:0] & pend_mask;
				pend_cnt_q <= cnt[2:0];
				total_q    <= total_q + TOTAL_W'(len_s1);
			end else if (s1_adv && op_s1 == OP_FLUSH) begin
				pend_q     <= '0;
				pend_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_cnt_q <= '0;
		end else if (s1_adv && s1_nres != '0) begin
			em_cnt_q <= s1_nres;
		end else if (res_fire) begin
			em_cnt_q <= em_cnt_q - EMC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_nres != '0) begin
			em_data_q  <= s1_data;
			em_total_q <= enc_hit ? total_q + TOTAL_W'(len_s1) : total_q;
		end else if (res_fire) begin
			em_data_q <= em_data_q << BYTE_W;
		end
	end

	assign res.valid         = em_cnt_q != '0;
	assign res.data.out_byte = em_data_q[EM_W-1 -: BYTE_W];
	assign res.data.last     = em_cnt_q == EMC_W'(1);
	assign res.data.bit_sum  = em_total_q;

	a_em_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_cnt_q <= EMC_W'(EM_BYTES))
		else $error("Byte buffer count exceeds its capacity.");

	a_stall_holds_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> ((rd_s1 === $past(rd_s1)) && (vld_s1 === $past(vld_s1))
		&& s1_valid_q))
		else $error("Table read data changed while the lookup stage was stalled.");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1 == OP_FLUSH) |=> (pend_cnt_q == '0 && pend_q == '0))
		else $error("Pending bits survived a flush.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> cmd.ready)
		else $error("Command channel stalled with an empty lookup stage.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_nres != '0) |-> (em_cnt_q == '0 || (res_fire && res.data.last)))
		else $error("New bytes loaded over undelivered bytes.");

endmodule
